### rtl/core/gpe_pkg.sv
// ----------------------------------------------------------------------------
// gpe_pkg: shared types and constants of the glyph placement engine
// Holds the item kinds, the packed glyph entry, the nudge selector and the
// saturating helpers used by the top level and the placement datapath.
// ----------------------------------------------------------------------------
package gpe_pkg;

    localparam int GPE_GLYPH_SLOTS = 256;
    localparam int GPE_COORD_SCALE = 16;

    localparam int COORD_W   = 24;
    localparam int OFFSET_W  = 24;
    localparam int CODE_W    = 16;
    localparam int AWIDTH_W  = 13;
    localparam int ATLAS_W   = 12;
    localparam int COLOR_W   = 24;
    localparam int ENTRY_W   = 64;
    // Room for a pen coordinate plus a bearing scaled by up to 256.
    localparam int CALC_W    = 28;
    // Atlas row times stride plus column.
    localparam int SRC_W     = 26;

    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 136;

    localparam logic signed [CALC_W-1:0] COORD_HI = CALC_W'(8388607);
    localparam logic signed [CALC_W-1:0] COORD_LO = -CALC_W'(8388608);
    localparam logic [SRC_W-1:0]         OFFSET_HI = SRC_W'(24'hFFFFFF);

    localparam logic [CODE_W-1:0] CHAR_LOWER_B = 16'h0062;
    localparam logic [CODE_W-1:0] CHAR_LOWER_C = 16'h0063;
    localparam logic [CODE_W-1:0] CHAR_LOWER_E = 16'h0065;
    localparam logic [CODE_W-1:0] CHAR_LOWER_A = 16'h0061;
    localparam logic [CODE_W-1:0] CHAR_LOWER_Z = 16'h007A;
    localparam logic [CODE_W-1:0] CHAR_UPPER_A = 16'h0041;
    localparam logic [CODE_W-1:0] CHAR_UPPER_Z = 16'h005A;
    localparam logic [CODE_W-1:0] CASE_BIT     = 16'h0020;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_START = 2'd2,
        KIND_PLACE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        NUDGE_NONE = 2'd0,
        NUDGE_HALF = 2'd1,
        NUDGE_LOW  = 2'd2
    } nudge_t;

    // Packed with the width in the lowest bits and the atlas row on top.
    typedef struct packed {
        logic [ATLAS_W-1:0] atlas_y;
        logic [ATLAS_W-1:0] atlas_x;
        logic signed [7:0]  advance;
        logic signed [7:0]  yoffset;
        logic signed [7:0]  xoffset;
        logic [7:0]         height;
        logic [7:0]         width;
    } glyph_entry_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] dest_x;
        logic signed [COORD_W-1:0] dest_y;
        logic [OFFSET_W-1:0]       source_offset;
        logic signed [COORD_W-1:0] next_pen_x;
    } place_result_t;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [CALC_W-1:0] v
    );
        logic signed [COORD_W-1:0] r;
        if (v > COORD_HI)
        begin
            r = COORD_HI[COORD_W-1:0];
        end
        else if (v < COORD_LO)
        begin
            r = COORD_LO[COORD_W-1:0];
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [OFFSET_W-1:0] sat_offset(input logic [SRC_W-1:0] v);
        logic [OFFSET_W-1:0] r;
        if (v > OFFSET_HI)
        begin
            r = OFFSET_HI[OFFSET_W-1:0];
        end
        else
        begin
            r = v[OFFSET_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/gpe_ram.sv
// ----------------------------------------------------------------------------
// gpe_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read; the read data
// holds while no read is enabled.
// ----------------------------------------------------------------------------
module gpe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/gpe_calc.sv
// ----------------------------------------------------------------------------
// gpe_calc: placement arithmetic for one character
// Works out the destination corner, the atlas offset and the advanced pen
// position from the current pen, the glyph entry, the nudge and the atlas stride.
// ----------------------------------------------------------------------------
module gpe_calc
    import gpe_pkg::*;
#(
    parameter int COORD_SCALE = GPE_COORD_SCALE
) (
    input  logic signed [COORD_W-1:0] pen_x,
    input  logic signed [COORD_W-1:0] pen_y,
    input  logic [AWIDTH_W-1:0]       atlas_width,
    input  glyph_entry_t              entry,
    input  nudge_t                    nudge,
    output place_result_t             result
);

    localparam logic signed [CALC_W-1:0] SCALE_S = CALC_W'(COORD_SCALE);
    localparam logic signed [CALC_W-1:0] NUDGE_HALF_V = CALC_W'(COORD_SCALE / 2);
    localparam logic signed [CALC_W-1:0] NUDGE_LOW_V = CALC_W'(COORD_SCALE - 4);

    logic signed [CALC_W-1:0] pen_x_e;
    logic signed [CALC_W-1:0] pen_y_e;
    logic signed [CALC_W-1:0] xo_e;
    logic signed [CALC_W-1:0] yo_e;
    logic signed [CALC_W-1:0] h_e;
    logic signed [CALC_W-1:0] adv_e;
    logic signed [CALC_W-1:0] nudge_e;
    logic signed [CALC_W-1:0] dx_sum;
    logic signed [CALC_W-1:0] dy_sum;
    logic signed [CALC_W-1:0] px_sum;
    logic [SRC_W-1:0]         src_sum;

    always_comb
    begin
        unique case (nudge)
            NUDGE_HALF: nudge_e = NUDGE_HALF_V;
            NUDGE_LOW:  nudge_e = NUDGE_LOW_V;
            default:    nudge_e = '0;
        endcase
    end

    assign pen_x_e = CALC_W'(pen_x);
    assign pen_y_e = CALC_W'(pen_y);
    assign xo_e    = CALC_W'(entry.xoffset);
    assign yo_e    = CALC_W'(entry.yoffset);
    assign adv_e   = CALC_W'(entry.advance);
    assign h_e     = signed'(CALC_W'(entry.height));

    assign dx_sum  = pen_x_e + xo_e * SCALE_S;
    assign dy_sum  = pen_y_e - (yo_e + h_e) * SCALE_S + nudge_e;
    assign px_sum  = pen_x_e + adv_e * SCALE_S;

    // A 12 by 13 bit product and one add; a zero stride leaves the column.
    assign src_sum = SRC_W'(entry.atlas_y) * SRC_W'(atlas_width) + SRC_W'(entry.atlas_x);

    assign result.dest_x        = sat_coord(dx_sum);
    assign result.dest_y        = sat_coord(dy_sum);
    assign result.next_pen_x    = sat_coord(px_sum);
    assign result.source_offset = sat_offset(src_sum);

endmodule

### rtl/core/glyph_placement_engine_core.sv
// ----------------------------------------------------------------------------
// glyph_placement_engine_core: glyph table lookup and pen placement
// Keeps a table of glyph descriptions by character code and turns a stream
// of clear, load, start and place beats into blit descriptions.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Handshake          Content
// s_axis     in         s_tvalid/s_tready  kind in s_tuser, item fields in s_tdata
// m_axis     out        m_tvalid/m_tready  glyph_found in m_tuser, blit in m_tdata
// config     in         cfg_we             atlas_width in cfg_wdata
//
// One beat is taken every cycle while the output can drain. An input beat
// is registered at the accept edge (table lookup and slot choice happen
// then), the glyph entry is read from the table RAM, and the placement
// arithmetic sits between that read register and the output register, so a
// place beat raises m_tvalid once the output register loads it from the
// middle stage. Clear, load and start beats give no result. Reset empties
// the table at once through its valid bits and sets the pen and color to
// zero and the stride to 256.
// When the output register is full and not taken, a place beat in the
// middle stage waits and s_tready drops until it can move on.
//
module glyph_placement_engine_core
    import gpe_pkg::*;
#(
    parameter int GLYPH_SLOTS = GPE_GLYPH_SLOTS,
    parameter int COORD_SCALE = GPE_COORD_SCALE
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0 up: glyph_code[15:0], glyph_width[23:16],
    // glyph_height[31:24], glyph_xoffset[39:32], glyph_yoffset[47:40],
    // glyph_advance[55:48], atlas_x[67:56], atlas_y[79:68],
    // start_x[103:80], start_y[127:104], color_rgb[151:128].
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // kind[1:0].
    input  logic [1:0]             s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0 up: blit_width[7:0], blit_height[15:8],
    // dest_x[39:16], dest_y[63:40], source_offset[87:64],
    // draw_color[111:88], next_pen_x[135:112].
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // glyph_found[0].
    output logic                   m_tuser,

    input  logic                   cfg_we,
    input  logic [AWIDTH_W-1:0]    cfg_wdata
);

    localparam int SLOT_W = $clog2(GLYPH_SLOTS);
    localparam logic [CODE_W-1:0] SLOT_LIMIT = CODE_W'(GLYPH_SLOTS);
    localparam logic [AWIDTH_W-1:0] ATLAS_WIDTH_RESET = AWIDTH_W'(256);

    // Input beat fields.
    kind_t                     in_kind;
    logic [CODE_W-1:0]         in_code;
    glyph_entry_t              in_entry;
    logic signed [COORD_W-1:0] in_start_x;
    logic signed [COORD_W-1:0] in_start_y;
    logic [COLOR_W-1:0]        in_color;

    assign in_kind             = kind_t'(s_tuser);
    assign in_code             = s_tdata[15:0];
    assign in_entry.width      = s_tdata[23:16];
    assign in_entry.height     = s_tdata[31:24];
    assign in_entry.xoffset    = s_tdata[39:32];
    assign in_entry.yoffset    = s_tdata[47:40];
    assign in_entry.advance    = s_tdata[55:48];
    assign in_entry.atlas_x    = s_tdata[67:56];
    assign in_entry.atlas_y    = s_tdata[79:68];
    assign in_start_x          = s_tdata[103:80];
    assign in_start_y          = s_tdata[127:104];
    assign in_color            = s_tdata[151:128];

    // Control state.
    logic [GLYPH_SLOTS-1:0]    present_reg;
    logic [AWIDTH_W-1:0]       atlas_width_reg;
    logic signed [COORD_W-1:0] pen_x_reg;
    logic signed [COORD_W-1:0] pen_y_reg;
    logic [COLOR_W-1:0]        color_reg;
    logic                      s1_valid_reg;
    logic                      m_tvalid_reg;

    // Middle stage payload.
    kind_t                     s1_kind_reg;
    logic                      s1_found_reg;
    nudge_t                    s1_nudge_reg;
    logic signed [COORD_W-1:0] s1_start_x_reg;
    logic signed [COORD_W-1:0] s1_start_y_reg;
    logic [COLOR_W-1:0]        s1_color_reg;

    // Output register payload.
    logic [OUT_TDATA_W-1:0]    out_data_reg;
    logic                      out_found_reg;
    logic [OUT_TDATA_W-1:0]    out_data_next;

    logic                      in_accept;
    logic                      out_free;
    logic                      s1_place;
    logic                      s1_fire;
    logic                      out_load;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s1_place  = s1_valid_reg && (s1_kind_reg == KIND_PLACE);
    assign s1_fire   = s1_valid_reg && (!s1_place || out_free);
    assign out_load  = s1_fire && s1_place;
    assign s_tready  = !s1_valid_reg || s1_fire;
    assign in_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Lookup at the accept edge: own slot first, then the opposite case
    // for ASCII letters.
    // ------------------------------------------------------------------
    logic              code_in_table;
    logic              own_found;
    logic              is_letter;
    logic [SLOT_W-1:0] own_slot;
    logic [SLOT_W-1:0] alt_slot;
    logic              alt_found;
    logic              lookup_found;
    logic [SLOT_W-1:0] lookup_slot;
    nudge_t            lookup_nudge;

    assign code_in_table = in_code < SLOT_LIMIT;
    assign own_slot      = in_code[SLOT_W-1:0];
    assign alt_slot      = own_slot ^ CASE_BIT[SLOT_W-1:0];
    assign own_found     = code_in_table && present_reg[own_slot];
    assign is_letter     = ((in_code >= CHAR_LOWER_A) && (in_code <= CHAR_LOWER_Z))
                        || ((in_code >= CHAR_UPPER_A) && (in_code <= CHAR_UPPER_Z));
    // Letters sit below 128, so with at least 128 slots the swapped slot is always in the table.
    assign alt_found     = is_letter && present_reg[alt_slot];
    assign lookup_found  = own_found || alt_found;
    assign lookup_slot   = own_found ? own_slot : alt_slot;

    always_comb
    begin
        if ((in_code == CHAR_LOWER_C) || (in_code == CHAR_LOWER_E))
        begin
            lookup_nudge = NUDGE_HALF;
        end
        else if (in_code == CHAR_LOWER_B)
        begin
            lookup_nudge = NUDGE_LOW;
        end
        else
        begin
            lookup_nudge = NUDGE_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Glyph table. Loads write at the accept edge; a place beat reads at
    // its accept edge, so a load right before it is already visible.
    // ------------------------------------------------------------------
    logic         ram_we;
    logic         ram_re;
    glyph_entry_t ram_rdata;

    assign ram_we = in_accept && (in_kind == KIND_LOAD) && code_in_table;
    assign ram_re = in_accept && (in_kind == KIND_PLACE);

    gpe_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (GLYPH_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (own_slot),
        .wdata (in_entry),
        .re    (ram_re),
        .raddr (lookup_slot),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Placement arithmetic on the middle stage.
    // ------------------------------------------------------------------
    place_result_t calc_result;

    gpe_calc #(
        .COORD_SCALE (COORD_SCALE)
    ) u_calc (
        .pen_x       (pen_x_reg),
        .pen_y       (pen_y_reg),
        .atlas_width (atlas_width_reg),
        .entry       (ram_rdata),
        .nudge       (s1_nudge_reg),
        .result      (calc_result)
    );

    // A missing glyph gives a zero beat that only carries the pen.
    always_comb
    begin
        if (s1_found_reg)
        begin
            out_data_next = {calc_result.next_pen_x, color_reg,
                             calc_result.source_offset, calc_result.dest_y,
                             calc_result.dest_x, ram_rdata.height, ram_rdata.width};
        end
        else
        begin
            out_data_next = {pen_x_reg, {(OUT_TDATA_W - COORD_W){1'b0}}};
        end
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg     <= '0;
            atlas_width_reg <= ATLAS_WIDTH_RESET;
            pen_x_reg       <= '0;
            pen_y_reg       <= '0;
            color_reg       <= '0;
            s1_valid_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                atlas_width_reg <= cfg_wdata;
            end

            if (in_accept && (in_kind == KIND_CLEAR))
            begin
                present_reg <= '0;
            end
            else if (ram_we)
            begin
                present_reg[own_slot] <= 1'b1;
            end

            if (s1_fire && (s1_kind_reg == KIND_START))
            begin
                pen_x_reg <= s1_start_x_reg;
                pen_y_reg <= s1_start_y_reg;
                color_reg <= s1_color_reg;
            end
            else if (out_load && s1_found_reg)
            begin
                pen_x_reg <= calc_result.next_pen_x;
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg    <= in_kind;
            s1_found_reg   <= lookup_found;
            s1_nudge_reg   <= lookup_nudge;
            s1_start_x_reg <= in_start_x;
            s1_start_y_reg <= in_start_y;
            s1_color_reg   <= in_color;
        end
        if (out_load)
        begin
            out_data_reg  <= out_data_next;
            out_found_reg <= s1_found_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_found_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_load_only_place: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (s1_valid_reg && (s1_kind_reg == KIND_PLACE)))
        else $error("output loaded from a beat that is not a place beat");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |-> !s_tready)
        else $error("input taken while the middle stage is stalled");

    a_missing_keeps_pen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !s1_found_reg) |=> (pen_x_reg == $past(pen_x_reg)))
        else $error("pen moved for a missing glyph");

    a_ram_one_port_use: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("table written and read by the same beat");

    a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_found_reg)))
        else $error("stalled middle stage lost its beat");

endmodule
